@@ hw/rtl/wra_pkg.sv @@
// ----------------------------------------------------------------------------
// wra_pkg
// Shared widths, codes and structs for the worker resource admission block.
// ----------------------------------------------------------------------------
package wra_pkg;

    localparam int MEM_BITS  = 48;
    localparam int CPU_BITS  = 10;
    localparam int FRAC_BITS = 16;

    localparam int UTIL_BITS = FRAC_BITS + 2;
    localparam int NUM_W     = MEM_BITS + 2;
    localparam int DEN_W     = MEM_BITS + 1;
    localparam int SUM_W     = MEM_BITS + 3;
    localparam int CNT_W     = $clog2(UTIL_BITS);
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        REQ_CHECK = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_FREE  = 2'd2
    } t_req_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPUS = 3'd0,
        CFG_PHYS = 3'd1,
        CFG_SWAP = 3'd2,
        CFG_RESV = 3'd3,
        CFG_GPU  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [MEM_BITS-1:0] min_mem;
        logic [MEM_BITS-1:0] max_mem;
        logic [MEM_BITS-1:0] base_mem;
        logic                threads_given;
        logic [CPU_BITS-1:0] thread_count;
        logic                wants_gpu;
    } t_req;

    typedef struct packed {
        logic [CPU_BITS:0] cpu;
        logic [MEM_BITS:0] mem_min;
        logic [MEM_BITS:0] mem_max;
        logic              gpu;
    } t_ledger;

    typedef struct packed {
        logic [CPU_BITS-1:0] worker_cpus;
        logic [MEM_BITS-1:0] physical;
        logic [MEM_BITS-1:0] swap;
        logic [MEM_BITS-1:0] reserved;
        logic                has_gpu;
    } t_cfg;

endpackage

@@ hw/rtl/wra_divider.sv @@
// ----------------------------------------------------------------------------
// wra_divider
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module wra_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [wra_pkg::NUM_W-1:0]      i_num,
    input  logic [wra_pkg::DEN_W-1:0]      i_den,
    output logic                           o_done,
    output logic [wra_pkg::UTIL_BITS-1:0]  o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic                            r_sat;
    logic [wra_pkg::CNT_W-1:0]       r_cnt;
    logic [wra_pkg::DEN_W-1:0]       r_rem;
    logic [wra_pkg::DEN_W-1:0]       r_den;
    logic [1:0]                      r_low;
    logic [wra_pkg::UTIL_BITS-1:0]   r_quot;

    logic [wra_pkg::DEN_W:0]         n_trial;
    logic                            n_fit;
    logic [wra_pkg::DEN_W-1:0]       n_rem;
    logic [wra_pkg::UTIL_BITS-1:0]   n_quot;
    logic                            n_sat;

    always_comb begin
        n_trial = {r_rem, r_low[1]};
        n_fit   = n_trial >= {1'b0, r_den};
        n_rem   = n_fit ? wra_pkg::DEN_W'(n_trial - {1'b0, r_den})
                        : wra_pkg::DEN_W'(n_trial);
        n_quot  = {r_quot[wra_pkg::UTIL_BITS-2:0], n_fit};
        // quotient would not fit the integer bits (also covers a zero divisor)
        n_sat   = {1'b0, i_num} >= {i_den, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= wra_pkg::CNT_W'(wra_pkg::UTIL_BITS - 1);
            r_rem  <= {1'b0, i_num[wra_pkg::NUM_W-1:2]};
            r_low  <= i_num[1:0];
            r_den  <= i_den;
            r_sat  <= n_sat;
            r_quot <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_rem  <= n_rem;
            r_low  <= {r_low[0], 1'b0};
            r_quot <= (r_cnt == '0 && r_sat) ? '1 : n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ hw/rtl/wra_ledger.sv @@
// ----------------------------------------------------------------------------
// wra_ledger
// Committed resource counters, saturating update and admission check.
// ----------------------------------------------------------------------------
module wra_ledger (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sum,
    input  logic              i_commit,
    input  wra_pkg::t_req     i_req,
    input  wra_pkg::t_cfg     i_cfg,
    output wra_pkg::t_ledger  o_ledger,
    output logic              o_ok
);

    wra_pkg::t_ledger                r_led;
    logic                            r_ok;
    logic [wra_pkg::SUM_W-1:0]       r_common;

    logic [wra_pkg::CPU_BITS-1:0]    n_cnt;
    logic [wra_pkg::SUM_W-1:0]       n_need_min;
    logic [wra_pkg::SUM_W-1:0]       n_need_max;
    logic [wra_pkg::DEN_W-1:0]       n_cap;
    logic [wra_pkg::CPU_BITS+1:0]    n_cpu_sum;
    logic [wra_pkg::CPU_BITS+1:0]    n_cpu_chk;
    logic [wra_pkg::MEM_BITS+1:0]    n_min_sum;
    logic [wra_pkg::MEM_BITS+1:0]    n_max_sum;
    logic                            n_ok;

    always_comb begin
        n_cnt      = i_req.threads_given ? i_req.thread_count : i_cfg.worker_cpus;
        n_need_min = r_common + wra_pkg::SUM_W'(i_req.min_mem);
        n_need_max = r_common + wra_pkg::SUM_W'(i_req.max_mem);
        n_cap      = {1'b0, i_cfg.physical} + {1'b0, i_cfg.swap};
        n_cpu_sum  = {1'b0, r_led.cpu} + (wra_pkg::CPU_BITS+2)'(n_cnt);
        n_cpu_chk  = {1'b0, r_led.cpu} + (wra_pkg::CPU_BITS+2)'(i_req.thread_count);
        n_min_sum  = {1'b0, r_led.mem_min} + (wra_pkg::MEM_BITS+2)'(i_req.min_mem);
        n_max_sum  = {1'b0, r_led.mem_max} + (wra_pkg::MEM_BITS+2)'(i_req.max_mem);

        n_ok = 1'b1;
        if (n_need_min > wra_pkg::SUM_W'(i_cfg.physical)) begin
            n_ok = 1'b0;
        end
        if (n_need_max > wra_pkg::SUM_W'(n_cap)) begin
            n_ok = 1'b0;
        end
        if (i_req.threads_given) begin
            if (n_cpu_chk > (wra_pkg::CPU_BITS+2)'(i_cfg.worker_cpus)) begin
                n_ok = 1'b0;
            end
        end else if (r_led.cpu != '0) begin
            n_ok = 1'b0;
        end
        if (i_cfg.has_gpu && i_req.wants_gpu && r_led.gpu) begin
            n_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sum) begin
            r_common <= wra_pkg::SUM_W'(i_cfg.reserved) + wra_pkg::SUM_W'(r_led.mem_min)
                      + wra_pkg::SUM_W'(i_req.base_mem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led <= '0;
            r_ok  <= 1'b0;
        end else if (i_commit) begin
            r_ok <= (i_req.req_type == wra_pkg::REQ_CHECK) && n_ok;
            unique case (i_req.req_type)
                wra_pkg::REQ_CHECK: begin
                end
                wra_pkg::REQ_ADD: begin
                    if (i_req.wants_gpu) begin
                        r_led.gpu <= 1'b1;
                    end
                    r_led.cpu <= n_cpu_sum[wra_pkg::CPU_BITS+1] ? '1
                               : n_cpu_sum[wra_pkg::CPU_BITS:0];
                    r_led.mem_min <= n_min_sum[wra_pkg::MEM_BITS+1] ? '1
                                   : n_min_sum[wra_pkg::MEM_BITS:0];
                    r_led.mem_max <= n_max_sum[wra_pkg::MEM_BITS+1] ? '1
                                   : n_max_sum[wra_pkg::MEM_BITS:0];
                end
                wra_pkg::REQ_FREE: begin
                    if (i_req.wants_gpu) begin
                        r_led.gpu <= 1'b0;
                    end
                    r_led.cpu <= ((wra_pkg::CPU_BITS+1)'(n_cnt) >= r_led.cpu) ? '0
                               : r_led.cpu - (wra_pkg::CPU_BITS+1)'(n_cnt);
                    r_led.mem_min <= ((wra_pkg::MEM_BITS+1)'(i_req.min_mem) >= r_led.mem_min)
                                   ? '0
                                   : r_led.mem_min - (wra_pkg::MEM_BITS+1)'(i_req.min_mem);
                    r_led.mem_max <= ((wra_pkg::MEM_BITS+1)'(i_req.max_mem) >= r_led.mem_max)
                                   ? '0
                                   : r_led.mem_max - (wra_pkg::MEM_BITS+1)'(i_req.max_mem);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ledger = r_led;
    assign o_ok     = r_ok;

endmodule

@@ hw/rtl/worker_resource_admission.sv @@
// Sequence: after the input transfer, a sum state and a check-and-update state, then
//   three ratios computed in turn on one shared 18-step divider, then the output.
// Input stalls until the result transfers, so no new request starts before that.
// Reset: synchronous, active low; counters and GPU flag cleared, worker CPUs and
//   physical memory set to 1, other control registers 0; request/datapath not reset.
// ----------------------------------------------------------------------------
// worker_resource_admission
// Admission check and resource bookkeeping for one worker with utilization.
// ----------------------------------------------------------------------------
module worker_resource_admission (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wra_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [wra_pkg::MEM_BITS-1:0]        i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_req_type,
    input  logic [wra_pkg::MEM_BITS-1:0]        i_min_mem,
    input  logic [wra_pkg::MEM_BITS-1:0]        i_max_mem,
    input  logic [wra_pkg::MEM_BITS-1:0]        i_base_mem,
    input  logic                                i_threads_given,
    input  logic [wra_pkg::CPU_BITS-1:0]        i_thread_count,
    input  logic                                i_wants_gpu,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_can_handle,
    output logic [wra_pkg::UTIL_BITS-1:0]       o_utilization
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_CHECK,
        S_LOAD,
        S_RUN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RATIO_CPU,
        RATIO_MIN,
        RATIO_MAX
    } t_ratio;

    t_state                          r_state;
    t_ratio                          r_sel;
    wra_pkg::t_cfg                   r_cfg;
    wra_pkg::t_req                   r_req;
    logic [wra_pkg::UTIL_BITS-1:0]   r_best;

    wra_pkg::t_ledger                w_led;
    logic                            w_ok;
    logic                            w_div_done;
    logic [wra_pkg::UTIL_BITS-1:0]   w_quot;
    logic [wra_pkg::NUM_W-1:0]       w_num;
    logic [wra_pkg::DEN_W-1:0]       w_den;
    logic                            w_accept;

    assign w_accept = i_valid && (r_state == S_IDLE);

    always_comb begin
        unique case (r_sel)
            RATIO_CPU: begin
                w_num = wra_pkg::NUM_W'(w_led.cpu);
                w_den = wra_pkg::DEN_W'(r_cfg.worker_cpus);
            end
            RATIO_MIN: begin
                w_num = {1'b0, w_led.mem_min} + wra_pkg::NUM_W'(r_cfg.reserved);
                w_den = wra_pkg::DEN_W'(r_cfg.physical);
            end
            RATIO_MAX: begin
                w_num = {1'b0, w_led.mem_max} + wra_pkg::NUM_W'(r_cfg.reserved);
                w_den = {1'b0, r_cfg.physical} + {1'b0, r_cfg.swap};
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.worker_cpus <= wra_pkg::CPU_BITS'(1);
            r_cfg.physical    <= wra_pkg::MEM_BITS'(1);
            r_cfg.swap        <= '0;
            r_cfg.reserved    <= '0;
            r_cfg.has_gpu     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wra_pkg::CFG_CPUS: r_cfg.worker_cpus <= i_cfg_data[wra_pkg::CPU_BITS-1:0];
                wra_pkg::CFG_PHYS: r_cfg.physical    <= i_cfg_data;
                wra_pkg::CFG_SWAP: r_cfg.swap        <= i_cfg_data;
                wra_pkg::CFG_RESV: r_cfg.reserved    <= i_cfg_data;
                wra_pkg::CFG_GPU:  r_cfg.has_gpu     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.req_type      <= i_req_type;
            r_req.min_mem       <= i_min_mem;
            r_req.max_mem       <= i_max_mem;
            r_req.base_mem      <= i_base_mem;
            r_req.threads_given <= i_threads_given;
            r_req.thread_count  <= i_thread_count;
            r_req.wants_gpu     <= i_wants_gpu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= RATIO_CPU;
            r_best  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_sel   <= RATIO_CPU;
                    r_best  <= '0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (w_div_done) begin
                        if (w_quot > r_best) begin
                            r_best <= w_quot;
                        end
                        if (r_sel == RATIO_MAX) begin
                            r_state <= S_OUT;
                        end else begin
                            r_sel   <= t_ratio'(r_sel + 2'd1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    wra_ledger u_ledger (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sum    (r_state == S_SUM),
        .i_commit (r_state == S_CHECK),
        .i_req    (r_req),
        .i_cfg    (r_cfg),
        .o_ledger (w_led),
        .o_ok     (w_ok)
    );

    wra_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_can_handle  = w_ok;
    assign o_utilization = r_best;

endmodule

@@ hw/rtl/wra_checker.sv @@
// ----------------------------------------------------------------------------
// wra_checker
// Port-level checks on the admission block's transfer sequencing.
// ----------------------------------------------------------------------------
module wra_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic                                o_can_handle,
    input  logic [wra_pkg::UTIL_BITS-1:0]       o_utilization
);

    // a pending result blocks new input
    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready while a result is pending");

    a_stall_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second input transfer right after the first");

    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid)
        else $error("result appeared one cycle after input transfer");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result repeated after output transfer");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_utilization)
                                  && $stable(o_can_handle)))
        else $error("stalled result changed");

endmodule

bind worker_resource_admission wra_checker u_wra_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_can_handle  (o_can_handle),
    .o_utilization (o_utilization)
);
